@@ rtl/core/extension_buffer_pool_defines.svh @@
// assertion macros for the extension buffer pool
// expects clk and rst_n in the scope of every use
`ifndef EXTENSION_BUFFER_POOL_DEFINES_SVH
`define EXTENSION_BUFFER_POOL_DEFINES_SVH

// property checked at every edge outside reset
`define EBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// condition followed by a consequence in the next cycle
`define EBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ebp_pkg.sv @@
// shared types, constants and helpers of the extension buffer pool
// used by every module of the block but ebp_ram, no dependencies
package ebp_pkg;

  localparam int NUM_BUFS  = 8;
  localparam int BUF_DEPTH = 4;

  localparam int BUF_IDX_W = (NUM_BUFS > 1) ? $clog2(NUM_BUFS) : 1;
  localparam int HEAD_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
  localparam int LEN_W     = $clog2(BUF_DEPTH + 2);
  localparam int SLOTS     = NUM_BUFS * BUF_DEPTH;
  localparam int ADDR_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int PID_W     = 16;
  localparam int PAY_W     = 32;
  localparam int OWNER_W   = 9;
  localparam int SLOT_W    = PID_W + PAY_W;

  localparam logic [OWNER_W-1:0] OWNER_NONE = '1;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 64;

  typedef enum logic [3:0] {
    MODE_SET_STATUS = 4'd0,
    MODE_FIND_FREE  = 4'd1,
    MODE_FIND_OWNER = 4'd2,
    MODE_RELEASE    = 4'd3,
    MODE_PUSH       = 4'd4,
    MODE_POP        = 4'd5,
    MODE_POP_KEEP   = 4'd6,
    MODE_POP_PUSH   = 4'd7,
    MODE_QUERY      = 4'd8,
    MODE_ADJUST     = 4'd9
  } ebp_mode_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } ebp_err_t;

  // packed from the top bit down, first field lands in the highest bits
  typedef struct packed {
    logic [2:0]         prior_length;
    logic [PID_W-1:0]   compare_packet_id;
    logic [PAY_W-1:0]   flit_payload;
    logic [PID_W-1:0]   flit_packet_id;
    logic [OWNER_W-1:0] owner_id;
    logic               occupied_flag;
    logic [2:0]         buf_index;
  } ebp_in_t;

  typedef struct packed {
    logic [2:0]       pad;
    logic [1:0]       error_code;
    logic [2:0]       forward_length;
    logic [2:0]       free_space;
    logic [PAY_W-1:0] popped_payload;
    logic [PID_W-1:0] popped_packet_id;
    logic             popped_valid;
    logic [2:0]       found_index;
    logic             found;
  } ebp_out_t;

  typedef struct packed {
    logic [PID_W-1:0] pid;
    logic [PAY_W-1:0] payload;
  } ebp_slot_t;

  typedef struct packed {
    logic [PID_W-1:0] a;
    logic [PID_W-1:0] b;
  } ebp_cmp_req_t;

  // position of the k-th flit behind the head in a circular buffer
  function automatic logic [HEAD_W-1:0] slot_pos(input logic [HEAD_W-1:0] head,
                                                 input logic [CNT_W-1:0] k);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(head) + (CNT_W+1)'(k);
    if (s >= (CNT_W+1)'(BUF_DEPTH)) begin
      s = s - (CNT_W+1)'(BUF_DEPTH);
    end
    return HEAD_W'(s);
  endfunction

  function automatic logic [LEN_W-1:0] sat7(input logic [LEN_W-1:0] v);
    logic [LEN_W+2:0] w;
    w = (LEN_W+3)'(v);
    return (w > (LEN_W+3)'(7)) ? 3'd7 : w[2:0];
  endfunction

endpackage

@@ rtl/core/ebp_ram.sv @@
// generic single write port ram with registered read
// no dependencies
module ebp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/ebp_cmp.sv @@
// shared equality comparator used by the buffer scans
// depends on ebp_pkg
module ebp_cmp (
  input  ebp_pkg::ebp_cmp_req_t req,
  output logic                  eq
);

  assign eq = (req.a == req.b);

endmodule

@@ rtl/core/extension_buffer_pool.sv @@
// top level of the extension buffer pool: sequencer, per-buffer state, result register
// depends on ebp_pkg, ebp_ram, ebp_cmp and extension_buffer_pool_defines.svh
//
// Usage:
//   in_* carries one operation per transaction, out_* returns exactly one result
//   per operation, in order. Operations are taken one at a time: in_tready is
//   high only while the sequencer waits for work.
//   Set status, release, push, adjust without head compare, a bad index or mode
//   finish at dispatch. Find free / find owner scan buffers from 0 and stop at
//   the first match (1 to NUM_BUFS scanned). Pops read the head slot; adjust with
//   head compare reads the head, then compares; query reads the head, compares
//   each further flit of the run and checks the head when the run fills the buffer.
//   The next operation can be accepted in the cycle after the result is registered.
//   The length of an operation is set by the scan over buffers or slots through the
//   single comparator and the one read port of the slot ram.
//   A result waits in the output register while out_tready is low; the
//   sequencer holds in its final step until the register is free.
//   Reset (rst_n low, synchronous) empties all buffers, clears busy marks and
//   sets every owner to none. Slot storage is not cleared and needs no pass.
module extension_buffer_pool (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // buf_index, occupied_flag, owner_id, flit_packet_id, flit_payload,
  // compare_packet_id, prior_length
  input  logic [ebp_pkg::IN_TDATA_W-1:0]  in_tdata,
  // mode
  input  logic [3:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // found, found_index, popped_valid, popped_packet_id, popped_payload,
  // free_space, forward_length, error_code, zero pad
  output logic [ebp_pkg::OUT_TDATA_W-1:0] out_tdata
);

`include "extension_buffer_pool_defines.svh"

  localparam int BW = ebp_pkg::BUF_IDX_W;
  localparam int HW = ebp_pkg::HEAD_W;
  localparam int CW = ebp_pkg::CNT_W;
  localparam int LW = ebp_pkg::LEN_W;
  localparam int AW = ebp_pkg::ADDR_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_FIND,
    ST_HEAD_RD,
    ST_HEAD_DAT,
    ST_RUN_RD,
    ST_RUN_CMP,
    ST_TAIL_CHK
  } state_t;

  state_t state_r, state_nxt;
  logic   done_r, done_nxt;

  logic [CW-1:0]              fill_r  [ebp_pkg::NUM_BUFS];
  logic [CW-1:0]              fill_nxt[ebp_pkg::NUM_BUFS];
  logic [HW-1:0]              head_r  [ebp_pkg::NUM_BUFS];
  logic [HW-1:0]              head_nxt[ebp_pkg::NUM_BUFS];
  logic                       busy_r  [ebp_pkg::NUM_BUFS];
  logic                       busy_nxt[ebp_pkg::NUM_BUFS];
  logic [ebp_pkg::OWNER_W-1:0] owner_r  [ebp_pkg::NUM_BUFS];
  logic [ebp_pkg::OWNER_W-1:0] owner_nxt[ebp_pkg::NUM_BUFS];

  logic [3:0]             mode_r, mode_nxt;
  ebp_pkg::ebp_in_t       op_r, op_nxt;
  logic                   range_ok_r, range_ok_nxt;
  logic [BW-1:0]          cur_r, cur_nxt;
  logic [CW-1:0]          k_r, k_nxt;
  logic [LW-1:0]          len_r, len_nxt;
  logic [ebp_pkg::PID_W-1:0] head_pid_r, head_pid_nxt;
  ebp_pkg::ebp_out_t      res_r, res_nxt;
  ebp_pkg::ebp_out_t      out_r, out_nxt;
  logic                   out_valid_r, out_valid_nxt;

  ebp_pkg::ebp_in_t       in_w;
  ebp_pkg::ebp_slot_t     rd_slot;
  ebp_pkg::ebp_slot_t     wr_slot;
  ebp_pkg::ebp_cmp_req_t  cmp_req;
  logic                   cmp_eq;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr, base_addr;
  logic [CW-1:0]          fill_c;
  logic [HW-1:0]          head_c;
  logic [LW-1:0]          len_inc;

  assign in_w      = ebp_pkg::ebp_in_t'(in_tdata);
  assign in_tready = (state_r == ST_IDLE) && !done_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = ebp_pkg::OUT_TDATA_W'(out_r);

  assign fill_c    = fill_r[cur_r];
  assign head_c    = head_r[cur_r];
  assign base_addr = AW'(int'(cur_r) * ebp_pkg::BUF_DEPTH);
  assign ram_raddr = base_addr + AW'(ebp_pkg::slot_pos(head_c, k_r));
  assign ram_waddr = base_addr + AW'(ebp_pkg::slot_pos(head_c, fill_c));
  assign wr_slot   = {op_r.flit_packet_id, op_r.flit_payload};
  assign len_inc   = len_r + LW'(1);

  ebp_ram #(
    .WIDTH (ebp_pkg::SLOT_W),
    .DEPTH (ebp_pkg::SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_slot),
    .raddr (ram_raddr),
    .rdata (rd_slot)
  );

  ebp_cmp u_cmp (
    .req (cmp_req),
    .eq  (cmp_eq)
  );

  always_comb begin
    state_nxt     = state_r;
    done_nxt      = 1'b0;
    fill_nxt      = fill_r;
    head_nxt      = head_r;
    busy_nxt      = busy_r;
    owner_nxt     = owner_r;
    mode_nxt      = mode_r;
    op_nxt        = op_r;
    range_ok_nxt  = range_ok_r;
    cur_nxt       = cur_r;
    k_nxt         = k_r;
    len_nxt       = len_r;
    head_pid_nxt  = head_pid_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    ram_we        = 1'b0;
    cmp_req.a     = op_r.compare_packet_id;
    cmp_req.b     = head_pid_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          op_nxt   = in_w;
          mode_nxt = in_tuser;
          if (in_tuser == ebp_pkg::MODE_FIND_FREE || in_tuser == ebp_pkg::MODE_FIND_OWNER) begin
            cur_nxt      = '0;
            range_ok_nxt = 1'b1;
          end else begin
            cur_nxt      = BW'(in_w.buf_index);
            range_ok_nxt = (int'(in_w.buf_index) < ebp_pkg::NUM_BUFS);
          end
          state_nxt = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        res_nxt   = '0;
        k_nxt     = '0;
        state_nxt = ST_IDLE;
        done_nxt  = 1'b1;
        if (range_ok_r) begin
          res_nxt.free_space = 3'(ebp_pkg::sat7(LW'(CW'(ebp_pkg::BUF_DEPTH) - fill_c)));
        end
        unique case (mode_r) inside
          ebp_pkg::MODE_FIND_FREE, ebp_pkg::MODE_FIND_OWNER: begin
            res_nxt.free_space = '0;
            state_nxt = ST_FIND;
            done_nxt  = 1'b0;
          end
          ebp_pkg::MODE_SET_STATUS: begin
            if (range_ok_r) begin
              busy_nxt[cur_r]  = op_r.occupied_flag;
              owner_nxt[cur_r] = op_r.owner_id;
            end
          end
          ebp_pkg::MODE_RELEASE: begin
            if (range_ok_r) begin
              busy_nxt[cur_r]  = 1'b0;
              owner_nxt[cur_r] = ebp_pkg::OWNER_NONE;
              fill_nxt[cur_r]  = '0;
              res_nxt.free_space = 3'(ebp_pkg::sat7(LW'(ebp_pkg::BUF_DEPTH)));
            end
          end
          ebp_pkg::MODE_PUSH: begin
            if (range_ok_r) begin
              if (fill_c == CW'(ebp_pkg::BUF_DEPTH)) begin
                res_nxt.error_code = ebp_pkg::ERR_FULL;
              end else begin
                ram_we          = 1'b1;
                fill_nxt[cur_r] = fill_c + CW'(1);
                res_nxt.free_space =
                  3'(ebp_pkg::sat7(LW'(CW'(ebp_pkg::BUF_DEPTH) - fill_c - CW'(1))));
              end
            end
          end
          ebp_pkg::MODE_POP, ebp_pkg::MODE_POP_KEEP, ebp_pkg::MODE_POP_PUSH,
          ebp_pkg::MODE_QUERY: begin
            if (range_ok_r) begin
              if (fill_c == '0) begin
                res_nxt.error_code = ebp_pkg::ERR_EMPTY;
              end else begin
                state_nxt = ST_HEAD_RD;
                done_nxt  = 1'b0;
              end
            end
          end
          ebp_pkg::MODE_ADJUST: begin
            if (range_ok_r) begin
              if (int'(op_r.prior_length) == ebp_pkg::BUF_DEPTH && fill_c != '0) begin
                len_nxt   = LW'(op_r.prior_length);
                state_nxt = ST_HEAD_RD;
                done_nxt  = 1'b0;
              end else begin
                res_nxt.forward_length = op_r.prior_length;
              end
            end
          end
          default: begin
            res_nxt = '0;
          end
        endcase
      end

      ST_FIND: begin
        if (mode_r == ebp_pkg::MODE_FIND_FREE) begin
          cmp_req.a = ebp_pkg::PID_W'(busy_r[cur_r]);
          cmp_req.b = '0;
        end else begin
          cmp_req.a = ebp_pkg::PID_W'(owner_r[cur_r]);
          cmp_req.b = ebp_pkg::PID_W'(op_r.owner_id);
        end
        if (cmp_eq) begin
          res_nxt.found       = 1'b1;
          res_nxt.found_index = 3'(cur_r);
          state_nxt = ST_IDLE;
          done_nxt  = 1'b1;
        end else if (cur_r == BW'(ebp_pkg::NUM_BUFS - 1)) begin
          state_nxt = ST_IDLE;
          done_nxt  = 1'b1;
        end else begin
          cur_nxt = cur_r + BW'(1);
        end
      end

      ST_HEAD_RD: begin
        state_nxt = ST_HEAD_DAT;
      end

      ST_HEAD_DAT: begin
        head_pid_nxt = rd_slot.pid;
        state_nxt    = ST_IDLE;
        done_nxt     = 1'b1;
        unique case (mode_r) inside
          ebp_pkg::MODE_POP, ebp_pkg::MODE_POP_KEEP, ebp_pkg::MODE_POP_PUSH: begin
            res_nxt.popped_valid     = 1'b1;
            res_nxt.popped_packet_id = rd_slot.pid;
            res_nxt.popped_payload   = rd_slot.payload;
            head_nxt[cur_r] = ebp_pkg::slot_pos(head_c, CW'(1));
            if (mode_r == ebp_pkg::MODE_POP_PUSH) begin
              ram_we = 1'b1;
            end else begin
              fill_nxt[cur_r] = fill_c - CW'(1);
              res_nxt.free_space =
                3'(ebp_pkg::sat7(LW'(CW'(ebp_pkg::BUF_DEPTH) - fill_c + CW'(1))));
              if (mode_r == ebp_pkg::MODE_POP && fill_c == CW'(1)) begin
                busy_nxt[cur_r]  = 1'b0;
                owner_nxt[cur_r] = ebp_pkg::OWNER_NONE;
              end
            end
          end
          ebp_pkg::MODE_QUERY: begin
            len_nxt = LW'(1);
            k_nxt   = CW'(1);
            if (fill_c > CW'(1)) begin
              state_nxt = ST_RUN_RD;
              done_nxt  = 1'b0;
            end else if (ebp_pkg::BUF_DEPTH == 1) begin
              state_nxt = ST_TAIL_CHK;
              done_nxt  = 1'b0;
            end else begin
              res_nxt.forward_length = 3'(ebp_pkg::sat7(LW'(1)));
            end
          end
          default: begin
            state_nxt = ST_TAIL_CHK;
            done_nxt  = 1'b0;
          end
        endcase
      end

      ST_RUN_RD: begin
        state_nxt = ST_RUN_CMP;
      end

      ST_RUN_CMP: begin
        cmp_req.a = rd_slot.pid;
        cmp_req.b = head_pid_r;
        if (cmp_eq && (k_r + CW'(1)) != fill_c) begin
          len_nxt   = len_inc;
          k_nxt     = k_r + CW'(1);
          state_nxt = ST_RUN_RD;
        end else begin
          if (cmp_eq) begin
            len_nxt = len_inc;
          end
          if ((cmp_eq ? len_inc : len_r) == LW'(ebp_pkg::BUF_DEPTH)) begin
            state_nxt = ST_TAIL_CHK;
          end else begin
            res_nxt.forward_length = 3'(ebp_pkg::sat7(cmp_eq ? len_inc : len_r));
            state_nxt = ST_IDLE;
            done_nxt  = 1'b1;
          end
        end
      end

      ST_TAIL_CHK: begin
        cmp_req.a = op_r.compare_packet_id;
        cmp_req.b = head_pid_r;
        res_nxt.forward_length = 3'(ebp_pkg::sat7(cmp_eq ? len_inc : len_r));
        state_nxt = ST_IDLE;
        done_nxt  = 1'b1;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // hold the sequencer until the output register can take the result
    if (done_r) begin
      if (!out_valid_r || out_tready) begin
        out_nxt       = res_r;
        out_valid_nxt = 1'b1;
      end else begin
        state_nxt = state_r;
        done_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
      range_ok_r  <= 1'b0;
      cur_r       <= '0;
      for (int i = 0; i < ebp_pkg::NUM_BUFS; i++) begin
        fill_r[i]  <= '0;
        head_r[i]  <= '0;
        busy_r[i]  <= 1'b0;
        owner_r[i] <= ebp_pkg::OWNER_NONE;
      end
    end else begin
      state_r     <= state_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
      range_ok_r  <= range_ok_nxt;
      cur_r       <= cur_nxt;
      fill_r      <= fill_nxt;
      head_r      <= head_nxt;
      busy_r      <= busy_nxt;
      owner_r     <= owner_nxt;
    end
    mode_r     <= mode_nxt;
    op_r       <= op_nxt;
    k_r        <= k_nxt;
    len_r      <= len_nxt;
    head_pid_r <= head_pid_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

  // the result waits while done is held, so no new transaction may start then
  `EBP_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready,
                   "input accepted again before the operation finished")
  `EBP_ASSERT(a_write_only_on_push,
              !ram_we || (state_r == ST_DISPATCH && mode_r == ebp_pkg::MODE_PUSH) ||
              (state_r == ST_HEAD_DAT && mode_r == ebp_pkg::MODE_POP_PUSH),
              "slot write outside a push step")
  `EBP_ASSERT(a_fill_bound, !range_ok_r || fill_r[cur_r] <= CW'(ebp_pkg::BUF_DEPTH),
              "buffer fill above depth")
  `EBP_ASSERT(a_error_no_pop, !out_valid_r || out_r.error_code == ebp_pkg::ERR_OK ||
              !out_r.popped_valid, "popped flit reported with an error")

endmodule

@@ bench/ebp_result_checker.sv @@
`timescale 1ns / 100ps
// result checker for the extension buffer pool: follows the pool state through every
// accepted operation and compares each result transaction, in order, field by field
// depends on ebp_pkg
module ebp_result_checker
  import ebp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [3:0]             in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     mismatch_count,
  output int                     outstanding
);

  localparam int MAX_REPORTS = 30;

  logic [PID_W-1:0]   flit_pid [NUM_BUFS][BUF_DEPTH];
  logic [PAY_W-1:0]   flit_word [NUM_BUFS][BUF_DEPTH];
  int                 fill [NUM_BUFS];
  logic               busy [NUM_BUFS];
  logic [OWNER_W-1:0] owner [NUM_BUFS];

  ebp_out_t expected_results[$];
  int       reports = 0;

  function automatic logic [2:0] clip7(input int v);
    return (v > 7) ? 3'd7 : 3'(v);
  endfunction

  function automatic void clear_pool();
    foreach (fill[b]) begin
      fill[b] = 0;
      busy[b] = 1'b0;
      owner[b] = OWNER_NONE;
    end
  endfunction

  function automatic ebp_out_t apply_operation(input logic [3:0] m, input ebp_in_t op);
    ebp_out_t r;
    int       b;
    int       i;
    int       run;
    bit       same;
    r = '0;
    b = op.buf_index;
    if (m == MODE_FIND_FREE || m == MODE_FIND_OWNER) begin
      for (i = 0; i < NUM_BUFS; i++) begin
        if (!r.found && ((m == MODE_FIND_FREE) ? !busy[i] : (owner[i] == op.owner_id))) begin
          r.found = 1'b1;
          r.found_index = 3'(i);
        end
      end
      return r;
    end
    if (m > MODE_ADJUST || b >= NUM_BUFS) begin
      return r;
    end
    case (m)
      MODE_SET_STATUS: begin
        busy[b] = op.occupied_flag;
        owner[b] = op.owner_id;
      end
      MODE_RELEASE: begin
        busy[b] = 1'b0;
        owner[b] = OWNER_NONE;
        fill[b] = 0;
      end
      MODE_PUSH: begin
        if (fill[b] >= BUF_DEPTH) begin
          r.error_code = ERR_FULL;
        end else begin
          flit_pid[b][fill[b]] = op.flit_packet_id;
          flit_word[b][fill[b]] = op.flit_payload;
          fill[b]++;
        end
      end
      MODE_POP, MODE_POP_KEEP, MODE_POP_PUSH: begin
        if (fill[b] == 0) begin
          r.error_code = ERR_EMPTY;
        end else begin
          r.popped_valid = 1'b1;
          r.popped_packet_id = flit_pid[b][0];
          r.popped_payload = flit_word[b][0];
          for (i = 1; i < fill[b]; i++) begin
            flit_pid[b][i-1] = flit_pid[b][i];
            flit_word[b][i-1] = flit_word[b][i];
          end
          fill[b]--;
          if (m == MODE_POP_PUSH) begin
            flit_pid[b][fill[b]] = op.flit_packet_id;
            flit_word[b][fill[b]] = op.flit_payload;
            fill[b]++;
          end else if (m == MODE_POP && fill[b] == 0) begin
            // last flit gone, buffer goes back to the free list
            busy[b] = 1'b0;
            owner[b] = OWNER_NONE;
          end
        end
      end
      MODE_QUERY: begin
        if (fill[b] == 0) begin
          r.error_code = ERR_EMPTY;
        end else begin
          run = 1;
          same = 1'b1;
          for (i = 1; i < fill[b]; i++) begin
            if (flit_pid[b][i] != flit_pid[b][0]) same = 1'b0;
            if (same) run++;
          end
          if (run == BUF_DEPTH && op.compare_packet_id == flit_pid[b][0]) run++;
          r.forward_length = clip7(run);
        end
      end
      default: begin
        if (op.prior_length == BUF_DEPTH && fill[b] != 0 &&
            op.compare_packet_id == flit_pid[b][0]) begin
          r.forward_length = clip7(int'(op.prior_length) + 1);
        end else begin
          r.forward_length = op.prior_length;
        end
      end
    endcase
    r.free_space = clip7(BUF_DEPTH - fill[b]);
    return r;
  endfunction

  function automatic int field_bad(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
    if (got === want) return 0;
    if (reports < MAX_REPORTS) begin
      $display("%0t ns mismatch %s: expected %0h, actual %0h", $time, what, want, got);
    end
    reports++;
    return 1;
  endfunction

  always @(posedge clk) begin
    int       errs;
    ebp_out_t got;
    ebp_out_t want;
    errs = 0;
    if (!rst_n) begin
      clear_pool();
      expected_results.delete();
      outstanding <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = ebp_out_t'(out_tdata);
        if (expected_results.size() == 0) begin
          errs++;
          if (reports < MAX_REPORTS) begin
            $display("%0t ns unexpected result transaction: expected none, actual %h",
                     $time, got);
          end
          reports++;
        end else begin
          want = expected_results.pop_front();
          errs += field_bad("found", want.found, got.found);
          errs += field_bad("found_index", want.found_index, got.found_index);
          errs += field_bad("popped_valid", want.popped_valid, got.popped_valid);
          errs += field_bad("popped_packet_id", want.popped_packet_id, got.popped_packet_id);
          errs += field_bad("popped_payload", want.popped_payload, got.popped_payload);
          errs += field_bad("free_space", want.free_space, got.free_space);
          errs += field_bad("forward_length", want.forward_length, got.forward_length);
          errs += field_bad("error_code", want.error_code, got.error_code);
          errs += field_bad("pad", want.pad, got.pad);
        end
      end
      if (in_tvalid && in_tready) begin
        expected_results.push_back(
          apply_operation(in_tuser, ebp_in_t'(in_tdata[$bits(ebp_in_t)-1:0])));
      end
      outstanding <= expected_results.size();
    end
    mismatch_count <= mismatch_count + errs;
  end

endmodule

@@ bench/extension_buffer_pool_test.sv @@
`timescale 1ns / 100ps
// top of the extension buffer pool testbench: clock, reset, operation stimulus with
// random gaps and result back-pressure, watchdog and final verdict
// depends on ebp_pkg, ebp_result_checker and the extension_buffer_pool rtl
module extension_buffer_pool_test;
  import ebp_pkg::*;

  localparam int IDLE_LIMIT    = 5000;
  localparam int SETTLE_CYCLES = 20;
  localparam int ITEM_TARGET   = 1200;
  localparam int LAST_MODE     = 15;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [3:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int               mismatch_count;
  int               outstanding;
  int               items_sent = 0;
  int               idle_cycles = 0;
  bit               in_calm = 1'b0;
  bit               out_calm = 1'b0;
  int               in_phase_left = 0;
  int               out_phase_left = 0;
  int               stall_left = 0;
  logic [PID_W-1:0] pid_pool [3];

  extension_buffer_pool i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  ebp_result_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .mismatch_count(mismatch_count),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side back-pressure: calm stretches, short stalls and a few long ones
  always @(posedge clk) begin
    if (out_phase_left == 0) begin
      out_calm = ($urandom_range(0, 3) == 0);
      out_phase_left = $urandom_range(30, 300);
    end else begin
      out_phase_left--;
    end
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (!out_calm && $urandom_range(0, 2) == 0) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic logic [PID_W-1:0] pick_pid();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return PID_W'($urandom);
      default: return pid_pool[$urandom_range(0, 2)];
    endcase
  endfunction

  function automatic logic [OWNER_W-1:0] pick_owner();
    case ($urandom_range(0, 5))
      0:       return OWNER_NONE;
      1:       return OWNER_W'($urandom);
      2:       return OWNER_W'($urandom_range(0, 255));
      default: return OWNER_W'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic ebp_in_t fields(input int b, input logic occ, input logic [OWNER_W-1:0] own,
                                     input logic [PID_W-1:0] pid, input logic [PAY_W-1:0] pay,
                                     input logic [PID_W-1:0] cmp, input logic [2:0] prior);
    ebp_in_t d;
    d.buf_index = 3'(b);
    d.occupied_flag = occ;
    d.owner_id = own;
    d.flit_packet_id = pid;
    d.flit_payload = pay;
    d.compare_packet_id = cmp;
    d.prior_length = prior;
    return d;
  endfunction

  function automatic ebp_in_t random_fields();
    return fields($urandom_range(0, 7), 1'($urandom), pick_owner(), pick_pid(),
                  PAY_W'($urandom), pick_pid(), 3'($urandom_range(0, 7)));
  endfunction

  task automatic send(input logic [3:0] m, input ebp_in_t d);
    int gap;
    if (in_phase_left == 0) begin
      in_calm = ($urandom_range(0, 3) == 0);
      in_phase_left = $urandom_range(20, 150);
    end else begin
      in_phase_left--;
    end
    gap = 0;
    if (!in_calm) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: gap = 0;
        19:      gap = $urandom_range(10, 40);
        default: gap = $urandom_range(1, 3);
      endcase
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_TDATA_W'(d);
    in_tuser <= m;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // allocate a buffer, fill it with mostly one packet, inspect it and pop flits from it
  task automatic buffer_lifecycle();
    int               b;
    logic [PID_W-1:0] p;
    ebp_in_t          d;
    b = $urandom_range(0, 7);
    p = pick_pid();
    send(MODE_FIND_FREE, random_fields());
    d = random_fields();
    d.buf_index = 3'(b);
    d.occupied_flag = 1'b1;
    send(MODE_SET_STATUS, d);
    send(MODE_FIND_OWNER, d);
    repeat ($urandom_range(1, BUF_DEPTH + 1)) begin
      d = random_fields();
      d.buf_index = 3'(b);
      if ($urandom_range(0, 4) != 0) d.flit_packet_id = p;
      send(MODE_PUSH, d);
    end
    d = random_fields();
    d.buf_index = 3'(b);
    if ($urandom_range(0, 1) == 0) d.compare_packet_id = p;
    send(MODE_QUERY, d);
    d = random_fields();
    d.buf_index = 3'(b);
    if ($urandom_range(0, 2) != 0) d.prior_length = 3'(BUF_DEPTH);
    if ($urandom_range(0, 1) == 0) d.compare_packet_id = p;
    send(MODE_ADJUST, d);
    repeat ($urandom_range(0, 2)) begin
      d = random_fields();
      d.buf_index = 3'(b);
      d.flit_packet_id = p;
      send(MODE_POP_PUSH, d);
    end
    repeat ($urandom_range(1, BUF_DEPTH + 1)) begin
      d = random_fields();
      d.buf_index = 3'(b);
      send(($urandom_range(0, 3) == 0) ? MODE_POP_KEEP : MODE_POP, d);
      if ($urandom_range(0, 2) == 0) begin
        d.compare_packet_id = p;
        send(MODE_QUERY, d);
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      d = random_fields();
      d.buf_index = 3'(b);
      send(MODE_RELEASE, d);
    end
  endtask

  // mark the whole pool busy so that find free runs out of candidates
  task automatic pool_sweep();
    ebp_in_t d;
    for (int b = 0; b < NUM_BUFS; b++) begin
      d = random_fields();
      d.buf_index = 3'(b);
      d.occupied_flag = 1'b1;
      send(MODE_SET_STATUS, d);
    end
    send(MODE_FIND_FREE, random_fields());
    send(MODE_FIND_OWNER, random_fields());
    d = random_fields();
    d.owner_id = OWNER_NONE;
    send(MODE_FIND_OWNER, d);
    repeat ($urandom_range(1, 4)) begin
      d = random_fields();
      d.occupied_flag = 1'b0;
      d.owner_id = OWNER_NONE;
      send(MODE_SET_STATUS, d);
    end
  endtask

  task automatic noise_burst();
    int m;
    repeat ($urandom_range(1, 5)) begin
      if ($urandom_range(0, 7) == 0) m = $urandom_range(int'(MODE_ADJUST) + 1, LAST_MODE);
      else m = $urandom_range(0, int'(MODE_ADJUST));
      send(4'(m), random_fields());
    end
  endtask

  initial begin
    int pick;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    foreach (pid_pool[i]) pid_pool[i] = PID_W'($urandom);

    // empty buffers, find modes on a fresh pool, a full buffer with one packet, undefined modes
    send(MODE_QUERY, fields(0, 0, OWNER_NONE, '0, '0, '0, 3'd0));
    send(MODE_POP, fields(0, 0, OWNER_NONE, '0, '0, '0, 3'd0));
    send(MODE_POP_KEEP, fields(1, 1, 9'h0FF, '1, '1, '1, 3'd7));
    send(MODE_POP_PUSH, fields(2, 0, OWNER_NONE, 16'h1234, 32'hCAFE0001, '0, 3'd0));
    send(MODE_ADJUST, fields(3, 0, OWNER_NONE, '0, '0, '0, 3'(BUF_DEPTH)));
    send(MODE_FIND_FREE, fields(0, 0, OWNER_NONE, '0, '0, '0, 3'd0));
    send(MODE_FIND_OWNER, fields(0, 0, OWNER_NONE, '0, '0, '0, 3'd0));
    send(MODE_FIND_OWNER, fields(0, 0, 9'h0FF, '0, '0, '0, 3'd0));
    send(MODE_SET_STATUS, fields(7, 1, 9'h0FF, '0, '0, '0, 3'd0));
    send(MODE_FIND_OWNER, fields(0, 0, 9'h0FF, '0, '0, '0, 3'd0));
    send(MODE_SET_STATUS, fields(0, 1, 9'h000, '0, '0, '0, 3'd0));
    send(MODE_PUSH, fields(7, 0, OWNER_NONE, '1, '1, '0, 3'd0));
    send(MODE_PUSH, fields(7, 0, OWNER_NONE, '1, '0, '0, 3'd0));
    send(MODE_PUSH, fields(7, 0, OWNER_NONE, '1, 32'h5A5A5A5A, '0, 3'd0));
    send(MODE_PUSH, fields(7, 0, OWNER_NONE, '1, 32'hA5A5A5A5, '0, 3'd0));
    send(MODE_PUSH, fields(7, 0, OWNER_NONE, '0, '1, '0, 3'd0));
    send(MODE_QUERY, fields(7, 0, OWNER_NONE, '0, '0, '1, 3'd0));
    send(MODE_ADJUST, fields(7, 0, OWNER_NONE, '0, '0, '1, 3'(BUF_DEPTH)));
    send(MODE_ADJUST, fields(7, 0, OWNER_NONE, '0, '0, '1, 3'd7));
    send(MODE_POP_PUSH, fields(7, 0, OWNER_NONE, '0, '0, '0, 3'd0));
    send(MODE_QUERY, fields(7, 0, OWNER_NONE, '0, '0, '1, 3'd0));
    send(MODE_POP_KEEP, fields(7, 0, OWNER_NONE, '0, '0, '0, 3'd0));
    send(4'(LAST_MODE), fields(7, 1, '1, '1, '1, '1, 3'd7));
    send(4'(int'(MODE_ADJUST) + 1), fields(7, 1, '1, '1, '1, '1, 3'd7));
    send(MODE_RELEASE, fields(7, 0, OWNER_NONE, '0, '0, '0, 3'd0));

    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) buffer_lifecycle();
      else if (pick < 9) noise_burst();
      else pool_sweep();
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/ebp_pkg.sv
rtl/core/ebp_ram.sv
rtl/core/ebp_cmp.sv
rtl/core/extension_buffer_pool.sv
bench/ebp_result_checker.sv
bench/extension_buffer_pool_test.sv
